### design/totient_table_sieve_macros.svh
// assertion macros for the totient table sieve
`ifndef TOTIENT_TABLE_SIEVE_MACROS_SVH
`define TOTIENT_TABLE_SIEVE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TTS_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tts_pkg.sv
// types, constants and sequencer states shared by the totient table sieve
`default_nettype none

package tts_pkg;

  localparam int unsigned MAX_ENTRIES      = 65536;
  localparam int unsigned PRIME_LIST_DEPTH = 64;
  localparam int unsigned VALUE_W          = 16;
  localparam int unsigned PHI_W            = 16;
  localparam int unsigned SMALL_LIMIT      = 16;
  localparam int unsigned SMALL_W          = $clog2(SMALL_LIMIT);

  localparam logic [PHI_W-1:0] SMALL_PHI [SMALL_LIMIT] = '{
    16'd0, 16'd1, 16'd1, 16'd2, 16'd2, 16'd4, 16'd2, 16'd6,
    16'd4, 16'd6, 16'd4, 16'd10, 16'd4, 16'd12, 16'd6, 16'd8
  };

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_READ  = 1'b1
  } tts_op_e;

  typedef struct packed {
    logic               opcode;
    logic [VALUE_W-1:0] value;
  } tts_in_t;

  typedef struct packed {
    logic [PHI_W-1:0] totient;
    logic             status;
  } tts_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_RESP,
    S_CLEAR,
    S_LOAD_I,
    S_CUR,
    S_PRIME,
    S_PJ,
    S_PWAIT,
    S_IDX,
    S_MOD,
    S_MUL,
    S_WR,
    S_EVEN,
    S_EV_RD,
    S_EV_WR,
    S_TAIL_RD,
    S_TAIL_CHK
  } tts_state_e;

endpackage

`default_nettype wire

### design/tts_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = tts_pkg::PHI_W,
  parameter int unsigned DEPTH = tts_pkg::MAX_ENTRIES,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/totient_table_sieve.sv
// totient table sieve top level: build sequencer, lookup path and output register
// read request: S_READ reads the table, S_RESP registers the result (errors skip S_READ)
//   and holds while the output stalls; next accept back in S_IDLE; build request: clear
//   0..bound (below 16 from a constant table), sieve odd i up to bound/2 (16-step remainder
//   unit), fill odd entries above bound/2, respond; one 16x16 multiplier serves every product
// reset: no table built, output empty; memories are not reset, each build clears 0..bound
`default_nettype none

module totient_table_sieve #(
  parameter int unsigned MAX_ENTRIES      = tts_pkg::MAX_ENTRIES,
  parameter int unsigned PRIME_LIST_DEPTH = tts_pkg::PRIME_LIST_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tts_pkg::tts_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tts_pkg::tts_out_t     out_data_o
);

  `include "totient_table_sieve_macros.svh"

  localparam int unsigned PHI_AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned PAW     = $clog2(PRIME_LIST_DEPTH);
  localparam int unsigned CW      = $clog2(PRIME_LIST_DEPTH + 1);
  localparam logic [31:0] MAX_IDX = 32'(MAX_ENTRIES - 1);

  tts_pkg::tts_state_e state_q, state_d;

  logic [15:0]       bound_q, bound_d;
  logic [15:0]       built_bound_q, built_bound_d;
  logic              table_valid_q, table_valid_d;
  logic [CW-1:0]     pcnt_q, pcnt_d;
  logic [CW-1:0]     j_q, j_d;
  logic [16:0]       i_q, i_d;
  logic [15:0]       idx_q, idx_d;
  logic [15:0]       cur_q, cur_d;
  logic [15:0]       p_q, p_d;
  logic              new_q, new_d;
  logic [31:0]       prod_q, prod_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       dvd_q, dvd_d;
  logic [3:0]        cnt_q, cnt_d;
  tts_pkg::tts_out_t res_q, res_d;
  tts_pkg::tts_out_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic        phi_we;
  logic [15:0] phi_wa16;
  logic [15:0] phi_wdata;
  logic [15:0] phi_ra16;
  logic [15:0] phi_rdata;
  logic        plist_we;
  logic [15:0] plist_wdata;
  logic [15:0] plist_rdata;

  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [16:0] rem_tmp;
  logic [16:0] nxt_i;
  logic [14:0] half;
  logic        small_bnd;
  logic [15:0] bound_sat;

  assign mul_p     = mul_a * mul_b;
  assign rem_tmp   = {rem_q, dvd_q[15]};
  assign nxt_i     = i_q + 17'd2;
  assign half      = bound_q[15:1];
  assign small_bnd = bound_q < 16'(tts_pkg::SMALL_LIMIT);
  assign bound_sat = (32'(in_data_i.value) > MAX_IDX) ? MAX_IDX[15:0] : in_data_i.value;

  tts_ram #(
    .WIDTH (tts_pkg::PHI_W),
    .DEPTH (MAX_ENTRIES)
  ) u_phi_ram (
    .clk_i   (clk_i),
    .we_i    (phi_we),
    .waddr_i (PHI_AW'(phi_wa16)),
    .wdata_i (phi_wdata),
    .raddr_i (PHI_AW'(phi_ra16)),
    .rdata_o (phi_rdata)
  );

  tts_ram #(
    .WIDTH (16),
    .DEPTH (PRIME_LIST_DEPTH)
  ) u_plist_ram (
    .clk_i   (clk_i),
    .we_i    (plist_we),
    .waddr_i (pcnt_q[PAW-1:0]),
    .wdata_i (plist_wdata),
    .raddr_i (j_q[PAW-1:0]),
    .rdata_o (plist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tts_pkg::S_IDLE;
      built_bound_q <= '0;
      table_valid_q <= 1'b0;
      pcnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      built_bound_q <= built_bound_d;
      table_valid_q <= table_valid_d;
      pcnt_q        <= pcnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    j_q     <= j_d;
    i_q     <= i_d;
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    p_q     <= p_d;
    new_q   <= new_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d       = state_q;
    bound_d       = bound_q;
    built_bound_d = built_bound_q;
    table_valid_d = table_valid_q;
    pcnt_d        = pcnt_q;
    j_d           = j_q;
    i_d           = i_q;
    idx_d         = idx_q;
    cur_d         = cur_q;
    p_d           = p_q;
    new_d         = new_q;
    prod_d        = prod_q;
    rem_d         = rem_q;
    dvd_d         = dvd_q;
    cnt_d         = cnt_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    phi_we        = 1'b0;
    phi_wa16      = idx_q;
    phi_wdata     = '0;
    phi_ra16      = i_q[15:0];
    plist_we      = 1'b0;
    plist_wdata   = i_q[15:0];
    mul_a         = i_q[15:0];
    mul_b         = i_q[15:0];

    unique case (state_q)
      tts_pkg::S_IDLE: begin
        phi_ra16 = in_data_i.value;
        if (in_valid_i) begin
          if (in_data_i.opcode == tts_pkg::OP_BUILD) begin
            bound_d       = bound_sat;
            built_bound_d = bound_sat;
            table_valid_d = 1'b1;
            pcnt_d        = '0;
            idx_d         = '0;
            state_d       = tts_pkg::S_CLEAR;
          end else if (!table_valid_q || in_data_i.value > built_bound_q) begin
            res_d   = '{totient: '0, status: tts_pkg::STATUS_ERR};
            state_d = tts_pkg::S_RESP;
          end else begin
            state_d = tts_pkg::S_READ;
          end
        end
      end
      tts_pkg::S_READ: begin
        res_d   = '{totient: phi_rdata, status: tts_pkg::STATUS_OK};
        state_d = tts_pkg::S_RESP;
      end
      tts_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = tts_pkg::S_IDLE;
        end
      end
      tts_pkg::S_CLEAR: begin
        phi_we   = 1'b1;
        phi_wa16 = idx_q;
        if (small_bnd) begin
          phi_wdata = tts_pkg::SMALL_PHI[idx_q[tts_pkg::SMALL_W-1:0]];
        end else begin
          phi_wdata = (idx_q == 16'd1) ? 16'd1 : 16'd0;
        end
        if (idx_q == bound_q) begin
          if (small_bnd) begin
            res_d   = '{totient: '0, status: tts_pkg::STATUS_OK};
            state_d = tts_pkg::S_RESP;
          end else begin
            i_d     = 17'd1;
            state_d = tts_pkg::S_LOAD_I;
          end
        end else begin
          idx_d = idx_q + 16'd1;
        end
      end
      tts_pkg::S_LOAD_I: begin
        phi_ra16 = i_q[15:0];
        state_d  = tts_pkg::S_CUR;
      end
      tts_pkg::S_CUR: begin
        new_d = (phi_rdata == '0);
        if (phi_rdata == '0) begin
          cur_d     = i_q[15:0] - 16'd1;
          phi_we    = 1'b1;
          phi_wa16  = i_q[15:0];
          phi_wdata = i_q[15:0] - 16'd1;
        end else begin
          cur_d = phi_rdata;
        end
        mul_a   = i_q[15:0];
        mul_b   = i_q[15:0];
        prod_d  = mul_p;
        state_d = tts_pkg::S_PRIME;
      end
      tts_pkg::S_PRIME: begin
        if (new_q && prod_q <= {16'd0, bound_q} && pcnt_q < CW'(PRIME_LIST_DEPTH)) begin
          plist_we    = 1'b1;
          plist_wdata = i_q[15:0];
          pcnt_d      = pcnt_q + CW'(1);
        end
        j_d     = '0;
        state_d = tts_pkg::S_PJ;
      end
      tts_pkg::S_PJ: begin
        if (j_q == pcnt_q) begin
          state_d = tts_pkg::S_EVEN;
        end else begin
          state_d = tts_pkg::S_PWAIT;
        end
      end
      tts_pkg::S_PWAIT: begin
        p_d     = plist_rdata;
        mul_a   = i_q[15:0];
        mul_b   = plist_rdata;
        prod_d  = mul_p;
        state_d = tts_pkg::S_IDX;
      end
      tts_pkg::S_IDX: begin
        if (prod_q > {16'd0, bound_q}) begin
          state_d = tts_pkg::S_EVEN;
        end else begin
          idx_d   = prod_q[15:0];
          dvd_d   = i_q[15:0];
          rem_d   = '0;
          cnt_d   = '0;
          state_d = tts_pkg::S_MOD;
        end
      end
      tts_pkg::S_MOD: begin
        if (rem_tmp >= {1'b0, p_q}) begin
          rem_d = 16'(rem_tmp - {1'b0, p_q});
        end else begin
          rem_d = rem_tmp[15:0];
        end
        dvd_d = {dvd_q[14:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'hf) begin
          state_d = tts_pkg::S_MUL;
        end
      end
      tts_pkg::S_MUL: begin
        mul_a   = cur_q;
        mul_b   = (rem_q == '0) ? p_q : p_q - 16'd1;
        prod_d  = mul_p;
        state_d = tts_pkg::S_WR;
      end
      tts_pkg::S_WR: begin
        phi_we    = 1'b1;
        phi_wa16  = idx_q;
        phi_wdata = prod_q[15:0];
        if (rem_q == '0) begin
          state_d = tts_pkg::S_EVEN;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = tts_pkg::S_PJ;
        end
      end
      tts_pkg::S_EVEN: begin
        phi_we    = 1'b1;
        phi_wa16  = {i_q[14:0], 1'b0};
        phi_wdata = cur_q;
        if (i_q + 17'd1 <= {2'd0, half}) begin
          state_d = tts_pkg::S_EV_RD;
        end else begin
          i_d = nxt_i;
          if (nxt_i <= {2'd0, half}) begin
            state_d = tts_pkg::S_LOAD_I;
          end else if (nxt_i <= {1'b0, bound_q}) begin
            state_d = tts_pkg::S_TAIL_RD;
          end else begin
            res_d   = '{totient: '0, status: tts_pkg::STATUS_OK};
            state_d = tts_pkg::S_RESP;
          end
        end
      end
      tts_pkg::S_EV_RD: begin
        phi_ra16 = i_q[15:0] + 16'd1;
        state_d  = tts_pkg::S_EV_WR;
      end
      tts_pkg::S_EV_WR: begin
        phi_we    = 1'b1;
        phi_wa16  = {i_q[14:0], 1'b0} + 16'd2;
        phi_wdata = {phi_rdata[14:0], 1'b0};
        i_d       = nxt_i;
        if (nxt_i <= {2'd0, half}) begin
          state_d = tts_pkg::S_LOAD_I;
        end else if (nxt_i <= {1'b0, bound_q}) begin
          state_d = tts_pkg::S_TAIL_RD;
        end else begin
          res_d   = '{totient: '0, status: tts_pkg::STATUS_OK};
          state_d = tts_pkg::S_RESP;
        end
      end
      tts_pkg::S_TAIL_RD: begin
        phi_ra16 = i_q[15:0];
        state_d  = tts_pkg::S_TAIL_CHK;
      end
      tts_pkg::S_TAIL_CHK: begin
        if (phi_rdata == '0) begin
          phi_we    = 1'b1;
          phi_wa16  = i_q[15:0];
          phi_wdata = i_q[15:0] - 16'd1;
        end
        i_d = nxt_i;
        if (nxt_i <= {1'b0, bound_q}) begin
          state_d = tts_pkg::S_TAIL_RD;
        end else begin
          res_d   = '{totient: '0, status: tts_pkg::STATUS_OK};
          state_d = tts_pkg::S_RESP;
        end
      end
      default: begin
        state_d = tts_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != tts_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TTS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request accepted but block not busy")
  `TTS_ASSERT(a_result_from_resp, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == tts_pkg::S_RESP, "result loaded outside response state")
  `TTS_ASSERT(a_phi_write_in_bound, clk_i, rst_ni, phi_we && state_q != tts_pkg::S_CLEAR, phi_wa16 <= bound_q, "sieve write beyond bound")
  `TTS_ASSERT(a_plist_room, clk_i, rst_ni, plist_we, pcnt_q < CW'(PRIME_LIST_DEPTH), "prime list write when full")

endmodule

`default_nettype wire
